// ===== rtl/mnee_pkg.sv =====
// Shared types, constants and helper functions for the MIDI note event encoder.
// No dependencies; used by every module of the block.
package mnee_pkg;

    // Input field widths
    localparam int KEY_W    = 8;
    localparam int FIELD_W  = 28;
    localparam int VOICE_W  = 4;
    localparam int PROG_W   = 8;
    localparam int BYTE_W   = 8;

    // Variable-length quantity layout
    localparam int VLQ_BYTES  = 4;
    localparam int GROUP_W    = 7;
    localparam int VLQ_BITS   = GROUP_W * VLQ_BYTES;
    localparam int VLQ_GROUPS = (FIELD_W + GROUP_W - 1) / GROUP_W;
    localparam int GIDX_W     = (VLQ_GROUPS > 1) ? $clog2(VLQ_GROUPS) : 1;

    // Queue between classifier and byte sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Event bytes
    localparam logic [BYTE_W-1:0]  PROG_CHG_STATUS = 8'hC0;
    localparam logic [BYTE_W-1:0]  NOTE_ON_STATUS  = 8'h90;
    localparam logic [BYTE_W-1:0]  VELOCITY_ON     = 8'd100;
    localparam logic [BYTE_W-1:0]  ZERO_BYTE       = 8'h00;
    localparam logic [VOICE_W-1:0] DRUM_CHANNEL    = 4'd9;
    localparam logic [VOICE_W-1:0] DRUM_VOICE_RST  = 4'd3;

    // One classified note as it travels through the queue
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PROG_W-1:0]  prog;
        logic [FIELD_W-1:0] delay;
        logic [GIDX_W-1:0]  delay_top;   // index of the most significant group
        logic [FIELD_W-1:0] len;
        logic [GIDX_W-1:0]  len_top;
        logic               first;
        logic [VOICE_W-1:0] chan;
    } note_desc_t;

    // Clamp a value to what VLQ_BYTES groups can carry
    function automatic logic [FIELD_W-1:0] vlq_sat(input logic [FIELD_W-1:0] v);
        logic [63:0]        maxv64;
        logic [FIELD_W-1:0] maxv;
        maxv64 = (64'd1 << VLQ_BITS) - 64'd1;
        maxv   = (VLQ_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : maxv64[FIELD_W-1:0];
        return (v > maxv) ? maxv : v;
    endfunction

    // Index of the highest non-zero 7-bit group (0 for a value below 128)
    function automatic logic [GIDX_W-1:0] vlq_top(input logic [FIELD_W-1:0] v);
        logic [GIDX_W-1:0] r;
        r = '0;
        for (int g = 1; g < VLQ_GROUPS; g++) begin
            if ((v >> (GROUP_W * g)) != '0) begin
                r = GIDX_W'(g);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/mnee_front.sv =====
// Front end: holds the drum voice register, accepts notes and classifies them
// into queue descriptors. Depends on mnee_pkg.
module mnee_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [mnee_pkg::VOICE_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mnee_pkg::KEY_W-1:0]   s_note_key,
    input  logic [mnee_pkg::FIELD_W-1:0] s_note_ticks,
    input  logic [mnee_pkg::FIELD_W-1:0] s_delay_ticks,
    input  logic                         s_first_of_voice,
    input  logic [mnee_pkg::VOICE_W-1:0] s_voice,
    input  logic [mnee_pkg::PROG_W-1:0]  s_program_req,
    input  logic                         q_full,
    output logic                         q_push,
    output mnee_pkg::note_desc_t         q_din
);
    import mnee_pkg::*;

    logic [VOICE_W-1:0] drum_voice_reg;
    logic [FIELD_W-1:0] delay_sat;
    logic [FIELD_W-1:0] len_sat;

    // Drum voice register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drum_voice_reg <= DRUM_VOICE_RST;
        end else if (cfg_wr_en) begin
            drum_voice_reg <= cfg_wr_data;
        end
    end

    // Accept whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify: saturate, size the quantities, pick the channel
    always_comb begin
        delay_sat       = vlq_sat(s_delay_ticks);
        len_sat         = vlq_sat(s_note_ticks);
        q_din.key       = s_note_key;
        q_din.prog      = s_program_req;
        q_din.delay     = delay_sat;
        q_din.delay_top = vlq_top(delay_sat);
        q_din.len       = len_sat;
        q_din.len_top   = vlq_top(len_sat);
        q_din.first     = s_first_of_voice;
        q_din.chan      = (s_voice == drum_voice_reg) ? DRUM_CHANNEL : s_voice;
    end

endmodule

// ===== rtl/mnee_queue.sv =====
// Short descriptor queue between the classifier and the byte sequencer.
// Depends on mnee_pkg.
module mnee_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mnee_pkg::note_desc_t din,
    output logic                 full,
    input  logic                 pop,
    output mnee_pkg::note_desc_t dout,
    output logic                 empty
);
    import mnee_pkg::*;

    note_desc_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update, wrapping at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/mnee_back.sv =====
// Back end: walks one queued note through its event bytes, one byte per cycle
// while m_ready does not stall it, into the output register. Depends on mnee_pkg.
module mnee_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mnee_pkg::note_desc_t        q_dout,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mnee_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last_byte
);
    import mnee_pkg::*;

    typedef enum logic [3:0] {
        PH_DELAY,
        PH_PROG_CHG,
        PH_PROG,
        PH_DELTA0,
        PH_NOTE_ON,
        PH_KEY_ON,
        PH_VEL_ON,
        PH_LEN,
        PH_KEY_OFF,
        PH_VEL_OFF
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [GIDX_W-1:0]   cnt_reg, cnt_next;
    logic                m_valid_reg;
    logic [BYTE_W-1:0]   m_out_byte_reg;
    logic                m_last_byte_reg;
    logic                step;
    logic [BYTE_W-1:0]   byte_val;
    logic                last_val;
    logic [FIELD_W-1:0]  vlq_val;
    logic [GIDX_W-1:0]   vlq_top_idx;
    logic [GIDX_W-1:0]   grp;
    logic                grp_last;

    assign step = !q_empty && (!m_valid_reg || m_ready);

    // Current VLQ group, most significant first
    always_comb begin
        vlq_val     = (phase_reg == PH_LEN) ? q_dout.len : q_dout.delay;
        vlq_top_idx = (phase_reg == PH_LEN) ? q_dout.len_top : q_dout.delay_top;
        grp         = vlq_top_idx - cnt_reg;
        grp_last    = (cnt_reg == vlq_top_idx);
    end

    // Byte selection and sequencing
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        byte_val   = ZERO_BYTE;
        last_val   = 1'b0;
        q_pop      = 1'b0;
        case (phase_reg)
            PH_DELAY, PH_LEN: begin
                byte_val = {!grp_last, 7'(vlq_val >> (GROUP_W * grp))};
                if (step) begin
                    if (grp_last) begin
                        cnt_next = '0;
                        if (phase_reg == PH_LEN) begin
                            phase_next = PH_KEY_OFF;
                        end else if (q_dout.first) begin
                            phase_next = PH_PROG_CHG;
                        end else begin
                            phase_next = PH_KEY_ON;
                        end
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            PH_PROG_CHG: begin
                byte_val = PROG_CHG_STATUS | {4'd0, q_dout.chan};
                if (step) phase_next = PH_PROG;
            end
            PH_PROG: begin
                byte_val = q_dout.prog;
                if (step) phase_next = PH_DELTA0;
            end
            PH_DELTA0: begin
                byte_val = ZERO_BYTE;
                if (step) phase_next = PH_NOTE_ON;
            end
            PH_NOTE_ON: begin
                byte_val = NOTE_ON_STATUS | {4'd0, q_dout.chan};
                if (step) phase_next = PH_KEY_ON;
            end
            PH_KEY_ON: begin
                byte_val = q_dout.key;
                if (step) phase_next = PH_VEL_ON;
            end
            PH_VEL_ON: begin
                byte_val = VELOCITY_ON;
                if (step) phase_next = PH_LEN;
            end
            PH_KEY_OFF: begin
                byte_val = q_dout.key;
                if (step) phase_next = PH_VEL_OFF;
            end
            PH_VEL_OFF: begin
                byte_val = ZERO_BYTE;
                last_val = 1'b1;
                if (step) begin
                    phase_next = PH_DELAY;
                    q_pop      = 1'b1;
                end
            end
            default: begin
                phase_next = PH_DELAY;
                cnt_next   = '0;
            end
        endcase
    end

    // Sequencer state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DELAY;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (step) begin
                m_valid_reg     <= 1'b1;
                m_out_byte_reg  <= byte_val;
                m_last_byte_reg <= last_val;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_last_byte = m_last_byte_reg;

endmodule

// ===== rtl/midi_note_event_encoder.sv =====
// MIDI note event encoder top level: classifier, descriptor queue, byte sequencer.
// Depends on mnee_pkg, mnee_front, mnee_queue and mnee_back.
//
// Turns each note into its MIDI track bytes: the delay as a variable-length
// quantity, then on a voice's first note a program change, a zero delta and a
// note-on status, then key, velocity 100, the length as a variable-length
// quantity, key and velocity 0. last_byte marks the final byte of a note. One
// byte leaves per cycle from the byte sequencer unless m_ready stalls it, so a
// note is 6 to 16 bytes long (1 to 4 bytes per quantity, plus 4 on a first
// note); that sequencer sets the sustained rate. A two-entry queue lets new
// notes be taken while earlier ones are still being emitted. Voices equal to
// drum_voice (written via cfg_wr_en/cfg_wr_data, reset 3) use channel 9.
module midi_note_event_encoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [mnee_pkg::VOICE_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mnee_pkg::KEY_W-1:0]   s_note_key,
    input  logic [mnee_pkg::FIELD_W-1:0] s_note_ticks,
    input  logic [mnee_pkg::FIELD_W-1:0] s_delay_ticks,
    input  logic                         s_first_of_voice,
    input  logic [mnee_pkg::VOICE_W-1:0] s_voice,
    input  logic [mnee_pkg::PROG_W-1:0]  s_program_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mnee_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                         m_last_byte
);
    import mnee_pkg::*;

    note_desc_t q_din, q_dout;
    logic       q_push, q_pop, q_full, q_empty;

    mnee_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_note_key       (s_note_key),
        .s_note_ticks     (s_note_ticks),
        .s_delay_ticks    (s_delay_ticks),
        .s_first_of_voice (s_first_of_voice),
        .s_voice          (s_voice),
        .s_program_req    (s_program_req),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_din            (q_din)
    );

    mnee_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    mnee_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_dout      (q_dout),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule
